/* rtl/swpr_pkg.sv */
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared types and constants of the sliding-window peak rate block.
// ----------------------------------------------------------------------------
package swpr_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned INDEX_W = 32;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned APB_AW  = 2;
    localparam int unsigned APB_DW  = 32;

    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60);

    // register map, byte address 4*index
    localparam logic [APB_AW-1:0] REG_WINDOW_SECS = APB_AW'(0);

    // one event handed from the front end to the back end
    typedef struct packed {
        logic [TIME_W-1:0]  event_time;   // clamped timestamp
        logic [INDEX_W-1:0] item_index;   // saturating item index
    } t_item;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_back_state;

endpackage

/* rtl/swpr_in_if.sv */
// ----------------------------------------------------------------------------
// swpr_in_if
// Event request channel: one timestamp per request.
// ----------------------------------------------------------------------------
interface swpr_in_if;
    logic                          valid;
    logic                          ready;
    logic [swpr_pkg::TIME_W-1:0]   event_time;

    modport source (output valid, output event_time, input ready);
    modport sink   (input valid, input event_time, output ready);
endinterface

/* rtl/swpr_out_if.sv */
// ----------------------------------------------------------------------------
// swpr_out_if
// Result request channel: window count and best window seen so far.
// ----------------------------------------------------------------------------
interface swpr_out_if;
    logic                           valid;
    logic                           ready;
    logic [swpr_pkg::COUNT_W-1:0]   current_count;
    logic [swpr_pkg::COUNT_W-1:0]   best_count;
    logic [swpr_pkg::TIME_W-1:0]    best_start_time;
    logic [swpr_pkg::TIME_W-1:0]    best_end_time;
    logic [swpr_pkg::INDEX_W-1:0]   best_start_index;
    logic [swpr_pkg::INDEX_W-1:0]   best_end_index;
    logic                           overflowed;

    modport source (
        output valid, output current_count, output best_count,
        output best_start_time, output best_end_time,
        output best_start_index, output best_end_index, output overflowed,
        input  ready
    );
    modport sink (
        input  valid, input current_count, input best_count,
        input  best_start_time, input best_end_time,
        input  best_start_index, input best_end_index, input overflowed,
        output ready
    );
endinterface

/* rtl/swpr_front.sv */
// ----------------------------------------------------------------------------
// swpr_front
// Accepts event requests, clamps decreasing timestamps and numbers items.
// ----------------------------------------------------------------------------
module swpr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swpr_in_if.sink               i_in,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output swpr_pkg::t_item       o_item
);

    logic [swpr_pkg::TIME_W-1:0]  r_newest;
    logic [swpr_pkg::INDEX_W-1:0] r_index;
    logic [swpr_pkg::TIME_W-1:0]  clamped;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;

    // clamp to the newest time, except for the very first event
    assign clamped = ((r_index != '0) && (i_in.event_time < r_newest))
                   ? r_newest : i_in.event_time;

    assign o_item.event_time = clamped;
    assign o_item.item_index = r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_index  <= '0;
        end else if (o_push) begin
            r_newest <= clamped;
            if (r_index != '1) begin
                r_index <= r_index + 1'b1;
            end
        end
    end

endmodule

/* rtl/swpr_queue.sv */
// ----------------------------------------------------------------------------
// swpr_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module swpr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  swpr_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_valid,
    output swpr_pkg::t_item   o_item,
    input  logic              i_pop
);

    swpr_pkg::t_item r_slot [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/swpr_back.sv */
// ----------------------------------------------------------------------------
// swpr_back
// Timestamp FIFO memory, pop scan over the window and peak tracking.
// ----------------------------------------------------------------------------
module swpr_back #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [swpr_pkg::TIME_W-1:0]   i_window_secs,
    input  logic                          i_q_valid,
    input  swpr_pkg::t_item               i_q_item,
    output logic                          o_q_pop,
    swpr_out_if.source                    o_out
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned TW    = swpr_pkg::TIME_W;
    localparam int unsigned IW    = swpr_pkg::INDEX_W;
    localparam int unsigned OW    = swpr_pkg::COUNT_W;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    swpr_pkg::t_back_state r_state, n_state;

    logic [TW-1:0]    r_mem [DEPTH];
    logic [TW-1:0]    r_rdata;
    logic [PTR_W-1:0] rd_addr;
    logic             mem_we;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_overflow, n_overflow;
    logic [TW-1:0]    r_t;
    logic [IW-1:0]    r_cur;
    logic             r_byp, n_byp;

    logic [CNT_W-1:0] r_peak_count, n_peak_count;
    logic [TW-1:0]    r_peak_start_time, n_peak_start_time;
    logic [TW-1:0]    r_peak_end_time, n_peak_end_time;
    logic [IW-1:0]    r_peak_start_index, n_peak_start_index;
    logic [IW-1:0]    r_peak_end_index, n_peak_end_index;

    logic             r_out_valid;
    logic [OW-1:0]    r_out_current;
    logic             r_out_overflow;

    logic             take;
    logic             pop;
    logic             finish;
    logic             out_free;
    logic [TW-1:0]    oldest;
    logic [TW-1:0]    span;
    logic [IW-1:0]    fill_less;
    logic [IW-1:0]    start_idx;
    logic [CNT_W+OW-1:0] fill_wide;

    assign out_free = !r_out_valid || o_out.ready;
    assign oldest   = r_byp ? r_t : r_rdata;
    assign span     = (r_t >= oldest) ? (r_t - oldest) : '0;
    assign pop      = (r_state == swpr_pkg::ST_SCAN) && (r_fill > CNT_W'(1))
                   && (span > i_window_secs);
    assign finish   = (r_state == swpr_pkg::ST_SCAN) && !pop && out_free;
    assign take     = (r_state == swpr_pkg::ST_IDLE) && i_q_valid;
    assign o_q_pop  = take;
    assign mem_we   = take;

    assign fill_less = IW'(r_fill) - IW'(1);
    assign start_idx = (r_cur >= fill_less) ? (r_cur - fill_less) : '0;
    assign fill_wide = {{OW{1'b0}}, r_fill};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swpr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = swpr_pkg::ST_SCAN;
                end
            end
            swpr_pkg::ST_SCAN: begin
                if (finish) begin
                    n_state = swpr_pkg::ST_IDLE;
                end
            end
            default: n_state = swpr_pkg::ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_head             = r_head;
        n_tail             = r_tail;
        n_fill             = r_fill;
        n_overflow         = r_overflow;
        n_byp              = r_byp;
        n_peak_count       = r_peak_count;
        n_peak_start_time  = r_peak_start_time;
        n_peak_end_time    = r_peak_end_time;
        n_peak_start_index = r_peak_start_index;
        n_peak_end_index   = r_peak_end_index;
        rd_addr            = r_head;
        if (take) begin
            // drop the oldest entry when the memory is full
            if (r_fill == CNT_W'(DEPTH)) begin
                n_head     = ptr_next(r_head);
                n_fill     = r_fill;
                n_overflow = 1'b1;
            end else begin
                n_fill = r_fill + 1'b1;
            end
            n_tail  = ptr_next(r_tail);
            n_byp   = (r_fill == '0);
            rd_addr = n_head;
        end else if (pop) begin
            n_head  = ptr_next(r_head);
            n_fill  = r_fill - 1'b1;
            n_byp   = 1'b0;
            rd_addr = n_head;
        end else if (finish && (r_fill > r_peak_count)) begin
            n_peak_count       = r_fill;
            n_peak_start_time  = oldest;
            n_peak_end_time    = r_t;
            n_peak_start_index = start_idx;
            n_peak_end_index   = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_q_item.event_time;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // hold count and overflow flag with the result; the next take may move
    // the live overflow flag while this result still waits
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_t   <= i_q_item.event_time;
            r_cur <= i_q_item.item_index;
        end
        if (finish) begin
            r_out_current  <= fill_wide[OW-1:0];
            r_out_overflow <= r_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= swpr_pkg::ST_IDLE;
            r_head             <= '0;
            r_tail             <= '0;
            r_fill             <= '0;
            r_overflow         <= 1'b0;
            r_byp              <= 1'b0;
            r_peak_count       <= '0;
            r_peak_start_time  <= '0;
            r_peak_end_time    <= '0;
            r_peak_start_index <= '0;
            r_peak_end_index   <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            r_state            <= n_state;
            r_head             <= n_head;
            r_tail             <= n_tail;
            r_fill             <= n_fill;
            r_overflow         <= n_overflow;
            r_byp              <= n_byp;
            r_peak_count       <= n_peak_count;
            r_peak_start_time  <= n_peak_start_time;
            r_peak_end_time    <= n_peak_end_time;
            r_peak_start_index <= n_peak_start_index;
            r_peak_end_index   <= n_peak_end_index;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic [CNT_W+OW-1:0] peak_wide;
    assign peak_wide = {{OW{1'b0}}, r_peak_count};

    // peak registers only change on finish, so they hold the result payload
    assign o_out.valid            = r_out_valid;
    assign o_out.current_count    = r_out_current;
    assign o_out.best_count       = peak_wide[OW-1:0];
    assign o_out.best_start_time  = r_peak_start_time;
    assign o_out.best_end_time    = r_peak_end_time;
    assign o_out.best_start_index = r_peak_start_index;
    assign o_out.best_end_index   = r_peak_end_index;
    assign o_out.overflowed       = r_out_overflow;

endmodule

/* rtl/sliding_window_peak_rate.sv */
// ----------------------------------------------------------------------------
// sliding_window_peak_rate
// Peak event count over a sliding time window, with best window tracking.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake            Carries
//  -------   ---   ------------------   ------------------------------------
//  i_in      in    valid/ready          event_time
//  o_out     out   valid/ready          counts, best window times/indices,
//                                       overflow flag
//  APB       in    psel/penable/pready  window_secs at byte address 0
//
//  In the back end an event is taken in the idle state; the scan state then
//  pops each entry that has fallen out of the window, and each timestamp is
//  popped at most once. No new event is taken until the scan ends. The pop
//  scan is bound by the one registered read port of the timestamp memory.
//  Reset is synchronous, active low, and clears all control state; the
//  timestamp memory needs no clearing since the fill count guards reads.
//  A two-entry queue lets the front end keep taking requests while the back
//  end scans or the result register waits on o_out.ready.
//
module sliding_window_peak_rate #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swpr_in_if.sink                       i_in,
    swpr_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swpr_pkg::APB_AW-1:0]   paddr,
    input  logic [swpr_pkg::APB_DW-1:0]   pwdata,
    output logic [swpr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // configuration register
    logic [swpr_pkg::TIME_W-1:0] r_window_secs;

    // front end to queue
    logic            front_push;
    swpr_pkg::t_item front_item;
    logic            q_ready;

    // queue to back end
    logic            q_valid;
    swpr_pkg::t_item q_item;
    logic            q_pop;

    // APB: zero-wait, write on the access phase
    assign pready = 1'b1;

    // only one register, so a write at every word address lands in it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_secs <= swpr_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_window_secs <= pwdata;
        end
    end

    // read back the window register at its address, zero elsewhere
    always_comb begin
        case (paddr)
            swpr_pkg::REG_WINDOW_SECS: prdata = r_window_secs;
            default:                   prdata = '0;
        endcase
    end

    // accept requests, clamp timestamps, assign item indices
    swpr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (front_push),
        .o_item    (front_item)
    );

    // decouple the request side from the scan
    swpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // push into the window, pop stale entries, update the peak
    swpr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_secs (r_window_secs),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out         (o_out)
    );

endmodule
